// ----- hdl/hskc_pkg.sv -----
// Shared types and constants for the hashed set-associative key cache.
// Holds the request, response and work item structs and the back-end state enum.
// No dependencies.
`default_nettype none
package hskc_pkg;

	// Geometry: SET_COUNT must be a power of two, at least 2.
	localparam int SET_COUNT = 256;
	localparam int WAY_COUNT = 4;
	localparam int SET_W     = $clog2(SET_COUNT);
	localparam int WAY_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

	localparam int KEY_W     = 64;
	localparam int HALF_W    = 32;
	localparam int WAYNUM_W  = 4;

	localparam logic [HALF_W-1:0] HASH_MUL_LO = 32'd73428767;
	localparam logic [HALF_W-1:0] HASH_MUL_HI = 32'd912931;
	localparam int                HASH_FOLD   = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_INSERT = 1'b1
	} action_t;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [WAYNUM_W-1:0] written_way;
	} rsp_t;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
		logic [SET_W-1:0] set;
	} work_t;

	typedef enum logic {
		ST_IDLE,
		ST_CMP
	} back_state_t;

endpackage
`default_nettype wire

// ----- hdl/hskc_front.sv -----
// Front end: accepts requests, hashes the key to a set index over two stages.
// Depends on hskc_pkg.
`default_nettype none
module hskc_front
	import hskc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire req_t  req,
	output logic       wq_push,
	input  wire logic  wq_full,
	output work_t      wq_data
);

	logic              valid_s1;
	logic              action_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [HALF_W-1:0] plo_s1;
	logic [HALF_W-1:0] phi_s1;

	logic              accept;
	logic              advance;
	logic [HALF_W-1:0] plo_d;
	logic [HALF_W-1:0] phi_d;
	logic [HALF_W-1:0] mix;
	logic [HALF_W-1:0] folded;

	assign advance = valid_s1 & ~wq_full;
	assign full    = valid_s1 & wq_full;
	assign accept  = push & ~full;

	// Both products wrap at 32 bits.
	assign plo_d = req.key[HALF_W-1:0] * HASH_MUL_LO;
	assign phi_d = req.key[KEY_W-1:HALF_W] * HASH_MUL_HI;

	assign mix    = plo_s1 ^ phi_s1;
	assign folded = mix ^ (mix >> HASH_FOLD);

	assign wq_push        = advance;
	assign wq_data.action = action_s1;
	assign wq_data.key    = key_s1;
	assign wq_data.set    = folded[SET_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= req.action;
			key_s1    <= req.key;
			plo_s1    <= plo_d;
			phi_s1    <= phi_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hskc_fifo.sv -----
// Work queue between the front end and the back end.
// Small register queue of hashed work items. Depends on hskc_pkg.
`default_nettype none
module hskc_fifo
	import hskc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire work_t din,
	input  wire logic  pop,
	output logic       empty,
	output work_t      dout
);

	work_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hskc_back.sv -----
// Back end: reads a whole set, compares all ways, picks the victim and, on an insert, updates the set.
// Holds the key and metadata memories and the response register. Depends on hskc_pkg.
`default_nettype none
module hskc_back
	import hskc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	output logic       wq_pop,
	input  wire logic  wq_empty,
	input  wire work_t wq_data,
	output logic       empty,
	input  wire logic  pop,
	output rsp_t       rsp
);

	localparam int ROW_W = WAY_COUNT * KEY_W;

	// Set-wide memories; one row per set.
	logic [ROW_W-1:0]     key_mem [SET_COUNT];
	logic [WAY_COUNT-1:0] vld_mem [SET_COUNT];
	logic [WAY_W-1:0]     ptr_mem [SET_COUNT];

	// A set whose flag is clear reads as all ways invalid, pointer zero.
	logic [SET_COUNT-1:0] row_init_q;

	back_state_t          state_q;
	back_state_t          state_d;

	work_t                work_q;
	logic [ROW_W-1:0]     key_row_q;
	logic [WAY_COUNT-1:0] vld_row_q;
	logic [WAY_W-1:0]     ptr_row_q;
	logic                 row_ok_q;

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 can_out;
	logic                 finish;
	logic                 is_insert;
	logic [WAY_COUNT-1:0] valid_v;
	logic [WAY_W-1:0]     ptr_v;
	logic [WAY_COUNT-1:0] match;
	logic                 any_free;
	logic [WAY_W-1:0]     free_way;
	logic [WAY_W-1:0]     victim;
	logic [WAY_W-1:0]     next_ptr;
	logic [WAY_W-1:0]     new_ptr;
	logic [WAY_COUNT-1:0] new_vld;
	logic [ROW_W-1:0]     new_row;
	rsp_t                 rsp_d;

	assign empty     = ~rsp_valid_q;
	assign rsp       = rsp_q;
	assign can_out   = ~rsp_valid_q | pop;
	assign is_insert = (work_q.action == ACT_INSERT);

	always_comb begin
		state_d = state_q;
		wq_pop  = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!wq_empty) begin
					wq_pop  = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (can_out) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign valid_v = row_ok_q ? vld_row_q : '0;
	assign ptr_v   = row_ok_q ? ptr_row_q : '0;

	always_comb begin
		match    = '0;
		any_free = 1'b0;
		free_way = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			match[w] = valid_v[w] && (key_row_q[w*KEY_W +: KEY_W] == work_q.key);
			if (!valid_v[w]) begin
				any_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	// Fill the lowest empty way; on a full set take the round-robin victim and advance.
	assign victim   = any_free ? free_way : ptr_v;
	assign next_ptr = (ptr_v == WAY_W'(WAY_COUNT - 1)) ? '0 : ptr_v + 1'b1;
	assign new_ptr  = any_free ? ptr_v : next_ptr;
	assign new_vld  = valid_v | (WAY_COUNT'(1) << victim);

	always_comb begin
		new_row = key_row_q;
		new_row[int'(victim)*KEY_W +: KEY_W] = work_q.key;
	end

	always_comb begin
		rsp_d.hit         = ~is_insert & (|match);
		rsp_d.written_way = is_insert ? WAYNUM_W'(victim) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			row_init_q  <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
				if (is_insert) begin
					row_init_q[work_q.set] <= 1'b1;
				end
			end else if (pop) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wq_pop) begin
			work_q    <= wq_data;
			key_row_q <= key_mem[wq_data.set];
			vld_row_q <= vld_mem[wq_data.set];
			ptr_row_q <= ptr_mem[wq_data.set];
			row_ok_q  <= row_init_q[wq_data.set];
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
		if (finish && is_insert) begin
			key_mem[work_q.set] <= new_row;
			vld_mem[work_q.set] <= new_vld;
			ptr_mem[work_q.set] <= new_ptr;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hashed_set_assoc_key_cache.sv -----
// Hashed set-associative key cache, top level.
// Path: front-end hash register, work queue, back-end row read and compare, response register.
// The back end finishes one request, reading a set row from memory and writing it back on
// an insert, before it reads the next row.
// Reset: asynchronous; clears queues, state, per-set init flags (all ways invalid,
// pointers zero). Key storage is not cleared.
`default_nettype none
module hashed_set_assoc_key_cache
	import hskc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	output logic      empty,
	input  wire logic pop,
	output rsp_t      rsp
);

	logic  wq_push;
	logic  wq_full;
	work_t wq_in;
	logic  wq_pop;
	logic  wq_empty;
	work_t wq_out;

	hskc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.wq_push (wq_push),
		.wq_full (wq_full),
		.wq_data (wq_in)
	);

	hskc_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wq_push),
		.full   (wq_full),
		.din    (wq_in),
		.pop    (wq_pop),
		.empty  (wq_empty),
		.dout   (wq_out)
	);

	hskc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wq_pop   (wq_pop),
		.wq_empty (wq_empty),
		.wq_data  (wq_out),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
